// File: src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: src/wrv_pkg.sv
// types and constants of the window regression velocity block
package wrv_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_CENTER    = 2'd1;

  localparam logic [19:0] TPS_RESET    = 20'd1000;
  localparam logic [9:0]  MIRROR_RESET = 10'd320;

  // shared multiplier operand width
  localparam int unsigned MUL_W = 33;

  // restoring divider: one quotient bit per step, bit 32 flags overflow
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd32;

  localparam logic [32:0] VEL_POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [32:0] VEL_NEG_LIMIT = 33'h0_8000_0000;

  typedef struct packed {
    logic        found;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [31:0] timestamp;
  } in_beat_t;

  typedef struct packed {
    logic signed [10:0] newest_x;
    logic [9:0]         newest_y;
    logic signed [31:0] velocity;
  } out_beat_t;

  typedef struct packed {
    logic signed [10:0] x;
    logic [31:0]        t;
  } sample_t;

  typedef enum logic [2:0] {
    MK_NONE,
    MK_NUM,
    MK_DEN,
    MK_PLO,
    MK_PHI
  } mul_kind_t;

  typedef struct packed {
    mul_kind_t               kind;
    logic signed [MUL_W-1:0] op_a;
    logic signed [MUL_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    mul_kind_t                 kind;
    logic signed [2*MUL_W-1:0] prod;
  } mul_rsp_t;

endpackage

// File: src/wrv_mul.sv
// shared signed multiplier with registered product and kind tag
module wrv_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  wrv_pkg::mul_req_t req,
  output wrv_pkg::mul_rsp_t rsp
);
  import wrv_pkg::*;

  mul_kind_t                 kind_r;
  logic signed [2*MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= MK_NONE;
    end else begin
      kind_r <= req.kind;
    end
    prod_r <= req.op_a * req.op_b;
  end

  assign rsp.kind = kind_r;
  assign rsp.prod = prod_r;

endmodule

// File: src/window_regression_velocity_top.sv
// a found beat runs pair walk, drain, magnitude, low and high product, wait, divider setup, divide, saturate,
// finish (divide and saturate skipped on a zero denominator); a beat without a find goes straight to finish
// in_stall holds new beats until the last result is registered; the work per beat is set by the single
// shared multiplier that walks all ordered sample pairs and by the 33-step restoring divider
// reset: synchronous active low, window cleared to zero, registers to 1000 and 320
`include "assert_macros.svh"

module window_regression_velocity_top #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  wrv_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output wrv_pkg::out_beat_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wrv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wrv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wrv_pkg::*;

  localparam int unsigned IDX_W      = $clog2(WINDOW);
  localparam int unsigned PAIR_STEPS = 2 * WINDOW * WINDOW;
  localparam int unsigned STEP_W     = $clog2(PAIR_STEPS + 1);
  localparam int unsigned SUM_GROW   = $clog2(WINDOW * WINDOW);
  localparam int unsigned NUM_W      = 44 + SUM_GROW;
  localparam int unsigned DEN_W      = 64 + SUM_GROW;
  localparam int unsigned MAG_W      = NUM_W - 1;
  localparam int unsigned PM_W       = MAG_W + 20;
  localparam int unsigned DIV_W      = DEN_W + 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR,
    S_DRAIN,
    S_MAG,
    S_PLO,
    S_PHI,
    S_PWAIT,
    S_DINIT,
    S_DIV,
    S_SAT,
    S_FINISH
  } state_t;

  state_t                 state_r;
  logic                   out_valid_r;
  out_beat_t              out_r;
  logic [STEP_W-1:0]      cnt_r;
  logic [IDX_W-1:0]       b_r;
  logic [DIV_CNT_W-1:0]   dcnt_r;

  logic [19:0]            tps_r;
  logic [9:0]             mirror_r;

  sample_t                win_r [WINDOW];
  sample_t                wb_r  [WINDOW];

  logic signed [10:0]     x_new_r;
  logic [9:0]             y_new_r;
  logic [31:0]            ts_r;
  logic signed [31:0]     vel_r;

  logic signed [MUL_W-1:0] dt_r;
  logic signed [11:0]      dx_r;
  logic signed [NUM_W-1:0] num_acc_r;
  logic [DEN_W-1:0]        den_acc_r;
  logic                    num_neg_r;
  logic [MAG_W-1:0]        num_mag_r;
  logic [PM_W-1:0]         p_acc_r;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        dsh_r;
  logic [32:0]             q_r;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic               in_acc;
  logic               out_fire;
  logic               load_pair;
  logic               wrap_a;
  logic               fin_go;
  logic               div_ge;
  logic [DIV_W-1:0]   div_diff;
  logic [32:0]        q_lim;
  logic [31:0]        vel_mag;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign load_pair = (state_r == S_PAIR) && !cnt_r[0] && (cnt_r != STEP_W'(PAIR_STEPS));
  assign wrap_a    = load_pair && (b_r == IDX_W'(WINDOW - 1));
  assign fin_go    = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  assign div_ge   = (rem_r >= dsh_r);
  assign div_diff = rem_r - dsh_r;
  assign q_lim    = num_neg_r ? VEL_NEG_LIMIT : VEL_POS_LIMIT;
  assign vel_mag  = (q_r > q_lim) ? q_lim[31:0] : q_r[31:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_req.kind = MK_NONE;
    mul_req.op_a = '0;
    mul_req.op_b = '0;
    case (state_r)
      S_PAIR: begin
        if (cnt_r[0]) begin
          mul_req.kind = MK_NUM;
          mul_req.op_a = dt_r;
          mul_req.op_b = MUL_W'(dx_r);
        end else if (cnt_r != '0) begin
          mul_req.kind = MK_DEN;
          mul_req.op_a = dt_r;
          mul_req.op_b = dt_r;
        end
      end
      S_PLO: begin
        mul_req.kind = MK_PLO;
        mul_req.op_a = MUL_W'(num_mag_r[31:0]);
        mul_req.op_b = MUL_W'(tps_r);
      end
      S_PHI: begin
        mul_req.kind = MK_PHI;
        mul_req.op_a = MUL_W'(num_mag_r[MAG_W-1:32]);
        mul_req.op_b = MUL_W'(tps_r);
      end
      default: begin
        mul_req.kind = MK_NONE;
      end
    endcase
  end

  wrv_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r    <= TPS_RESET;
      mirror_r <= MIRROR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_r    <= cfg_data;
        CFG_MIRROR_CENTER:    mirror_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sample window, rotated once per row of pairs, shifted on completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        win_r[k] <= '0;
      end
    end else if (fin_go) begin
      for (int k = 0; k < WINDOW - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WINDOW-1] <= {x_new_r, ts_r};
    end else if (wrap_a) begin
      for (int k = 0; k < WINDOW - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WINDOW-1] <= win_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wb_r      <= win_r;
      x_new_r   <= in_data.found ?
                   ($signed({1'b0, mirror_r}) - $signed({1'b0, in_data.pos_x})) : '0;
      y_new_r   <= in_data.found ? in_data.pos_y : '0;
      ts_r      <= in_data.timestamp;
      vel_r     <= '0;
      num_acc_r <= '0;
      den_acc_r <= '0;
    end
    if (load_pair) begin
      dt_r <= $signed({1'b0, win_r[0].t}) - $signed({1'b0, wb_r[0].t});
      dx_r <= 12'(win_r[0].x) - 12'(wb_r[0].x);
      for (int k = 0; k < WINDOW - 1; k++) begin
        wb_r[k] <= wb_r[k+1];
      end
      wb_r[WINDOW-1] <= wb_r[0];
    end
    case (mul_rsp.kind)
      MK_NUM: num_acc_r <= num_acc_r + NUM_W'(mul_rsp.prod);
      MK_DEN: den_acc_r <= den_acc_r + DEN_W'(mul_rsp.prod[63:0]);
      MK_PLO: p_acc_r   <= p_acc_r + PM_W'(mul_rsp.prod[2*MUL_W-2:0]);
      MK_PHI: p_acc_r   <= p_acc_r + (PM_W'(mul_rsp.prod[2*MUL_W-2:0]) << 32);
      default: ;
    endcase
    if (state_r == S_MAG) begin
      num_neg_r <= num_acc_r[NUM_W-1];
      num_mag_r <= MAG_W'(num_acc_r[NUM_W-1] ? -num_acc_r : num_acc_r);
      p_acc_r   <= '0;
    end
    if (state_r == S_DINIT) begin
      rem_r <= DIV_W'({p_acc_r, 8'b0});
      dsh_r <= {den_acc_r, 32'b0};
      q_r   <= '0;
    end
    if (state_r == S_DIV) begin
      rem_r <= div_ge ? div_diff : rem_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[31:0], div_ge};
    end
    if (state_r == S_SAT) begin
      vel_r <= num_neg_r ? -vel_mag : vel_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      b_r         <= '0;
      dcnt_r      <= '0;
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cnt_r   <= '0;
            b_r     <= '0;
            state_r <= in_data.found ? S_PAIR : S_FINISH;
          end
        end
        S_PAIR: begin
          if (load_pair) begin
            b_r <= wrap_a ? '0 : b_r + 1'b1;
          end
          if (cnt_r == STEP_W'(PAIR_STEPS)) begin
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN: state_r <= S_MAG;
        S_MAG:   state_r <= S_PLO;
        S_PLO:   state_r <= S_PHI;
        S_PHI:   state_r <= S_PWAIT;
        S_PWAIT: state_r <= S_DINIT;
        S_DINIT: begin
          dcnt_r  <= '0;
          state_r <= (den_acc_r == '0) ? S_FINISH : S_DIV;
        end
        S_DIV: begin
          if (dcnt_r == DIV_LAST) begin
            state_r <= S_SAT;
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
          end
        end
        S_SAT: state_r <= S_FINISH;
        S_FINISH: begin
          if (fin_go) begin
            out_valid_r    <= 1'b1;
            out_r.newest_x <= x_new_r;
            out_r.newest_y <= y_new_r;
            out_r.velocity <= vel_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_found_starts_pairs, in_acc && in_data.found |=> state_r == S_PAIR, "found beat did not start pair walk")
  `ASSERT_IMPL(a_out_from_finish, $rose(out_valid_r) |-> $past(state_r) == S_FINISH, "result beat raised outside finish")
  `ASSERT_NEVER(a_div_nonzero_den, state_r == S_DIV && den_acc_r == '0, "divide with zero denominator")
  `ASSERT_NEVER(a_pair_count, state_r == S_PAIR && cnt_r > STEP_W'(PAIR_STEPS), "pair counter overrun")

endmodule
